[rtl/silu_pkg.sv]
package silu_pkg;

  // Number of entries the list can hold.
  localparam int unsigned CAPACITY   = 16;
  // Width at which values are stored and compared.
  localparam int unsigned VALUE_BITS = 32;
  // Width of the interface value fields.
  localparam int unsigned FIELD_BITS = 32;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DUMP   = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ins;        // insert the request value and load its result row
    logic empty_row;  // load the row for a dump of an empty list
    logic idx_clr;    // start a dump from the smallest entry
    logic dump_row;   // load the entry at the dump index and advance
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // no stored values
    logic dump_last;  // the dump index points at the final stored value
  } sts_t;

endpackage

[rtl/silu_ctrl.sv]
module silu_ctrl
  import silu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic kind_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   load;

  // The output register can take a new row when empty or being emptied now.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (kind_i == KIND_INSERT) begin
            cmd_o.ins = 1'b1;
            load      = 1'b1;
          end else if (sts_i.empty) begin
            cmd_o.empty_row = 1'b1;
            load            = 1'b1;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_DUMP;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          cmd_o.dump_row = 1'b1;
          load           = 1'b1;
          if (sts_i.dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/silu_dp.sv]
module silu_dp
  import silu_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [FIELD_BITS-1:0] value_i,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o,
  output logic signed [FIELD_BITS-1:0] item_value_o,
  output logic                         insert_ok_o,
  output logic                         list_empty_o,
  output logic                         is_last_o
);

  logic [VALUE_BITS-1:0] cell_q [CAPACITY];
  logic [VALUE_BITS-1:0] cell_d [CAPACITY];
  logic [CAPACITY-1:0]   lt;
  logic [VALUE_BITS-1:0] val_ext;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  full;
  logic                  do_shift;

  logic [FIELD_BITS-1:0] item_q, item_d;
  logic                  ok_q, ok_d;
  logic                  empty_q, empty_d;
  logic                  last_q, last_d;

  assign val_ext  = VALUE_BITS'(value_i);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign do_shift = cmd_i.ins && !full;

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.dump_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  // Compare-and-shift cells. Entries are sorted, so lt is a thermometer code;
  // the first cell whose stored value is not smaller takes the new value and
  // every cell above it takes its lower neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign lt[i] = (CNT_W'(i) < count_q) &&
                   ($signed(cell_q[i]) < $signed(val_ext));
    if (i == 0) begin : g_head
      always_comb begin
        cell_d[i] = cell_q[i];
        if (do_shift && !lt[i]) begin
          cell_d[i] = val_ext;
        end
      end
    end else begin : g_body
      always_comb begin
        cell_d[i] = cell_q[i];
        if (do_shift && !lt[i]) begin
          cell_d[i] = lt[i-1] ? val_ext : cell_q[i-1];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    item_d  = item_q;
    ok_d    = ok_q;
    empty_d = empty_q;
    last_d  = last_q;
    if (do_shift) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end
    if (cmd_i.ins) begin
      item_d  = '0;
      ok_d    = !full;
      empty_d = 1'b0;
      last_d  = 1'b1;
    end else if (cmd_i.empty_row) begin
      item_d  = '0;
      ok_d    = 1'b0;
      empty_d = 1'b1;
      last_d  = 1'b1;
    end else if (cmd_i.dump_row) begin
      item_d  = FIELD_BITS'(cell_q[idx_q]);
      ok_d    = 1'b0;
      empty_d = 1'b0;
      last_d  = sts_o.dump_last;
      idx_d   = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    ok_q    <= ok_d;
    empty_q <= empty_d;
    last_q  <= last_d;
  end

  assign item_value_o = item_q;
  assign insert_ok_o  = ok_q;
  assign list_empty_o = empty_q;
  assign is_last_o    = last_q;

endmodule

[rtl/sorted_insert_list_unit.sv]
// Sorted insertion list: an insert request gives its result row in the cycle after acceptance.
// Inserts sustain one request per cycle while the output is taken each cycle.
// A dump of N stored values first clears the dump index and then streams one row a cycle
// while the output is taken; the next request is not accepted before the final row is loaded.
// Reset (rst_ni low, asynchronous) empties the list and clears the output valid flag;
// the stored values themselves are not cleared.
module sorted_insert_list_unit
  import silu_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic signed [FIELD_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [FIELD_BITS-1:0] item_value_o,
  output logic                         insert_ok_o,
  output logic                         list_empty_o,
  output logic                         is_last_o
);

  // The controller owns the handshakes and sequences a dump; the datapath
  // holds the cell chain, the fill count, the dump index and the output row.
  cmd_t cmd;
  sts_t sts;

  silu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Each cell compares its entry with the incoming value in parallel, so an
  // insert completes in the cycle it is accepted. A full list refuses the
  // value and reports it on insert_ok_o.
  silu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .item_value_o (item_value_o),
    .insert_ok_o  (insert_ok_o),
    .list_empty_o (list_empty_o),
    .is_last_o    (is_last_o)
  );

endmodule
